@@ rtl/atd_pkg.sv @@
// Shared constants for the affine TRS decomposition pipeline.
// No dependencies; imported by every module of the block.
package atd_pkg;

   // field geometry
   localparam int DATA_WIDTH = 32;
   localparam int NUM_ROW    = 3;
   localparam int NUM_AXIS   = 3;
   localparam int NUM_ELEM   = NUM_ROW * NUM_AXIS;
   localparam int NUM_QUAT   = 4;

   // square root unit: 2N-bit radicand, N-bit root, one root bit per stage
   localparam int SQ_OUT_W = DATA_WIDTH;
   localparam int SQ_IN_W  = 2 * SQ_OUT_W;
   localparam int SQ_REM_W = SQ_OUT_W + 4;

   // divider unit: 2N-bit dividend, (N+1)-bit divisor, N quotient bits
   localparam int DV_Q_W   = DATA_WIDTH;
   localparam int DV_NUM_W = 2 * DV_Q_W;
   localparam int DV_DEN_W = DV_Q_W + 1;

   // fraction bits of the Q2.30 results
   localparam int FRAC_Q30 = 30;

endpackage

@@ rtl/atd_sqrt.sv @@
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on atd_pkg.
module atd_sqrt import atd_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [SQ_IN_W-1:0]  radicand,
   output logic [SQ_OUT_W-1:0] root
);

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [SQ_OUT_W-1:0] root;
      logic [SQ_IN_W-1:0]  x;
   } sq_stage_type;

   sq_stage_type stage_ff [SQ_OUT_W];
   sq_stage_type stage_in [SQ_OUT_W];
   sq_stage_type seed;

   // one digit step: bring down two radicand bits, try root*4+1
   function automatic sq_stage_type sq_step(sq_stage_type cur);
      sq_stage_type        nxt;
      logic [SQ_REM_W-1:0] acc;
      logic [SQ_REM_W-1:0] trial;
      acc   = {cur.rem[SQ_REM_W-3:0], cur.x[SQ_IN_W-1 -: 2]};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = acc - trial;
         nxt.root = {cur.root[SQ_OUT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = acc;
         nxt.root = {cur.root[SQ_OUT_W-2:0], 1'b0};
      end
      nxt.x = {cur.x[SQ_IN_W-3:0], 2'b00};
      return nxt;
   endfunction

   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.x    = radicand;
      stage_in[0] = sq_step(seed);
      for (int k = 1; k < SQ_OUT_W; k++) begin
         stage_in[k] = sq_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQ_OUT_W; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign root = stage_ff[SQ_OUT_W-1].root;

endmodule

@@ rtl/atd_div.sv @@
// Pipelined restoring divider: unsigned dividend over unsigned divisor,
// overflow check in the first stage, then one quotient bit per stage. Uses atd_pkg.
module atd_div import atd_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [DV_NUM_W-1:0] numer,
   input  logic [DV_DEN_W-1:0] denom,
   output logic [DV_Q_W-1:0]   quo,
   output logic                ovf
);

   typedef struct packed {
      logic [DV_DEN_W-1:0] rem;
      logic [DV_Q_W-1:0]   quo;
      logic [DV_Q_W-1:0]   low;
      logic [DV_DEN_W-1:0] den;
      logic                ovf;
   } dv_stage_type;

   dv_stage_type stage_ff [DV_Q_W+1];
   dv_stage_type stage_in [DV_Q_W+1];

   // shift in one dividend bit, subtract when it fits
   function automatic dv_stage_type dv_step(dv_stage_type cur);
      dv_stage_type        nxt;
      logic [DV_DEN_W:0]   acc;
      logic [DV_DEN_W:0]   dz;
      logic [DV_DEN_W:0]   diff;
      acc  = {cur.rem, cur.low[DV_Q_W-1]};
      dz   = {1'b0, cur.den};
      diff = acc - dz;
      if (acc >= dz) begin
         nxt.rem = diff[DV_DEN_W-1:0];
         nxt.quo = {cur.quo[DV_Q_W-2:0], 1'b1};
      end else begin
         nxt.rem = acc[DV_DEN_W-1:0];
         nxt.quo = {cur.quo[DV_Q_W-2:0], 1'b0};
      end
      nxt.low = {cur.low[DV_Q_W-2:0], 1'b0};
      nxt.den = cur.den;
      nxt.ovf = cur.ovf;
      return nxt;
   endfunction

   // quotient overflows N bits when the high half already reaches the divisor
   always_comb begin
      stage_in[0].rem = {1'b0, numer[DV_NUM_W-1:DV_Q_W]};
      stage_in[0].quo = '0;
      stage_in[0].low = numer[DV_Q_W-1:0];
      stage_in[0].den = denom;
      stage_in[0].ovf = ({1'b0, numer[DV_NUM_W-1:DV_Q_W]} >= denom);
      for (int k = 1; k <= DV_Q_W; k++) begin
         stage_in[k] = dv_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DV_Q_W; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign quo = stage_ff[DV_Q_W].quo;
   assign ovf = stage_ff[DV_Q_W].ovf;

endmodule

@@ rtl/atd_basis.sv @@
// Column lengths and normalized basis: squares, sums, root, per-element divide.
// Depends on atd_pkg, atd_sqrt and atd_div.
module atd_basis import atd_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   elem,
   input  logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   move,
   output logic                                  out_valid,
   output logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   basis,
   output logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   len,
   output logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   out_move
);

   typedef struct packed {
      logic [NUM_ELEM-1:0]                  neg;
      logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]  mag;
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  move;
   } sq_side_type;

   typedef struct packed {
      logic [NUM_ELEM-1:0]                  neg;
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  len;
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  move;
   } dv_side_type;

   // stage 1: magnitudes and squares
   logic                                  p1_valid_ff;
   logic [NUM_ELEM-1:0]                   p1_neg_ff, p1_neg_in;
   logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   p1_mag_ff, p1_mag_in;
   logic [NUM_ELEM-1:0][SQ_IN_W-1:0]      p1_sq_ff, p1_sq_in;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   p1_move_ff;

   always_comb begin
      for (int j = 0; j < NUM_ELEM; j++) begin
         p1_neg_in[j] = elem[j][DATA_WIDTH-1];
         p1_mag_in[j] = p1_neg_in[j] ? (~elem[j] + 1'b1) : elem[j];
         p1_sq_in[j]  = p1_mag_in[j] * p1_mag_in[j];
      end
   end

   // stage 2: sum of squares per column
   logic                                  p2_valid_ff;
   sq_side_type                           p2_side_ff;
   logic [NUM_AXIS-1:0][SQ_IN_W-1:0]      p2_sum_ff, p2_sum_in;

   always_comb begin
      for (int c = 0; c < NUM_AXIS; c++) begin
         p2_sum_in[c] = p1_sq_ff[c*NUM_ROW] + p1_sq_ff[c*NUM_ROW+1] + p1_sq_ff[c*NUM_ROW+2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_neg_ff       <= p1_neg_in;
         p1_mag_ff       <= p1_mag_in;
         p1_sq_ff        <= p1_sq_in;
         p1_move_ff      <= move;
         p2_side_ff.neg  <= p1_neg_ff;
         p2_side_ff.mag  <= p1_mag_ff;
         p2_side_ff.move <= p1_move_ff;
         p2_sum_ff       <= p2_sum_in;
      end
   end

   // column length roots
   logic [NUM_AXIS-1:0][SQ_OUT_W-1:0] root;

   for (genvar c = 0; c < NUM_AXIS; c++) begin : g_sqrt
      atd_sqrt u_sqrt (
         .clock    (clock),
         .en       (en),
         .radicand (p2_sum_ff[c]),
         .root     (root[c])
      );
   end

   // side data riding alongside the root pipeline
   logic [SQ_OUT_W-1:0] sq_valid_ff;
   sq_side_type         sq_side_ff [SQ_OUT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (en) begin
         sq_valid_ff <= {sq_valid_ff[SQ_OUT_W-2:0], p2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= p2_side_ff;
         for (int k = 1; k < SQ_OUT_W; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // normalize each element: mag * 2^30 / len
   logic [NUM_ELEM-1:0][DV_Q_W-1:0] quo;
   logic [NUM_ELEM-1:0]             ovf;

   for (genvar j = 0; j < NUM_ELEM; j++) begin : g_div
      atd_div u_div (
         .clock (clock),
         .en    (en),
         .numer ({2'b00, sq_side_ff[SQ_OUT_W-1].mag[j], {FRAC_Q30{1'b0}}}),
         .denom ({1'b0, root[j / NUM_ROW]}),
         .quo   (quo[j]),
         .ovf   (ovf[j])
      );
   end

   logic [DV_Q_W:0] dv_valid_ff;
   dv_side_type     dv_side_ff [DV_Q_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else if (en) begin
         dv_valid_ff <= {dv_valid_ff[DV_Q_W-1:0], sq_valid_ff[SQ_OUT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0].neg  <= sq_side_ff[SQ_OUT_W-1].neg;
         dv_side_ff[0].len  <= root;
         dv_side_ff[0].move <= sq_side_ff[SQ_OUT_W-1].move;
         for (int k = 1; k <= DV_Q_W; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // stage 4: restore sign; a zero-length column stays all zero
   logic                                  p4_valid_ff;
   logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   p4_basis_ff, p4_basis_in;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   p4_len_ff;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   p4_move_ff;

   // the quotient never exceeds 2^30, so the overflow flag is set only for a zero-length column
   always_comb begin
      for (int j = 0; j < NUM_ELEM; j++) begin
         if (dv_side_ff[DV_Q_W].len[j / NUM_ROW] == '0 || ovf[j]) begin
            p4_basis_in[j] = '0;
         end else if (dv_side_ff[DV_Q_W].neg[j]) begin
            p4_basis_in[j] = ~quo[j] + 1'b1;
         end else begin
            p4_basis_in[j] = quo[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p4_valid_ff <= dv_valid_ff[DV_Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_basis_ff <= p4_basis_in;
         p4_len_ff   <= dv_side_ff[DV_Q_W].len;
         p4_move_ff  <= dv_side_ff[DV_Q_W].move;
      end
   end

   assign out_valid = p4_valid_ff;
   assign basis     = p4_basis_ff;
   assign len       = p4_len_ff;
   assign out_move  = p4_move_ff;

endmodule

@@ rtl/atd_quat.sv @@
// Shepperd quaternion extraction from the normalized basis: branch select,
// root argument, root, three quotients and saturation. Uses atd_pkg, atd_sqrt, atd_div.
module atd_quat import atd_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   basis,
   input  logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   len,
   input  logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   move,
   output logic                                  out_valid,
   output logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   out_move,
   output logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   scale,
   output logic [NUM_QUAT-1:0][DATA_WIDTH-1:0]   quat,
   output logic                                  deg
);

   localparam int ARG_W = DATA_WIDTH + 2;
   localparam int ND_W  = DATA_WIDTH + 1;

   // element index = column * 3 + row
   localparam int B00 = 0;
   localparam int B10 = 1;
   localparam int B20 = 2;
   localparam int B01 = 3;
   localparam int B11 = 4;
   localparam int B21 = 5;
   localparam int B02 = 6;
   localparam int B12 = 7;
   localparam int B22 = 8;

   localparam logic signed [ARG_W-1:0] ONE_Q30 = ARG_W'(1) << FRAC_Q30;

   typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} br_type;

   typedef struct packed {
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  move;
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  scale;
      br_type                               br;
      logic [NUM_QUAT-1:0]                  nneg;
      logic [NUM_QUAT-1:0][DATA_WIDTH-1:0]  nmag;
      logic                                 deg;
   } sq_side_type;

   typedef struct packed {
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  move;
      logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]  scale;
      br_type                               br;
      logic [NUM_QUAT-1:0]                  nneg;
      logic                                 deg;
      logic [SQ_OUT_W-1:0]                  r;
   } dv_side_type;

   function automatic logic signed [ARG_W-1:0] sx(logic [DATA_WIDTH-1:0] v);
      return {{2{v[DATA_WIDTH-1]}}, v};
   endfunction

   function automatic logic signed [ND_W-1:0] nx(logic [DATA_WIDTH-1:0] v);
      return {v[DATA_WIDTH-1], v};
   endfunction

   // signed 32-bit saturation of a sign and magnitude quotient
   function automatic logic [DATA_WIDTH-1:0] sat(logic o, logic [DV_Q_W-1:0] m, logic n);
      logic [DATA_WIDTH-1:0] res;
      if (n) begin
         res = (o || m > {1'b1, {(DV_Q_W-1){1'b0}}}) ?
               {1'b1, {(DATA_WIDTH-1){1'b0}}} : (~m + 1'b1);
      end else begin
         res = (o || m[DV_Q_W-1]) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : m;
      end
      return res;
   endfunction

   // stage 1: trace and branch choice
   logic                                  q1_valid_ff;
   logic [NUM_ELEM-1:0][DATA_WIDTH-1:0]   q1_b_ff;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   q1_len_ff;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   q1_move_ff;
   logic signed [ARG_W-1:0]               q1_tr_ff, q1_tr_in;
   br_type                                q1_br_ff, q1_br_in;

   always_comb begin
      q1_tr_in = sx(basis[B00]) + sx(basis[B11]) + sx(basis[B22]);
      if (q1_tr_in > 0) begin
         q1_br_in = BR_W;
      end else if ($signed(basis[B00]) > $signed(basis[B11]) &&
                   $signed(basis[B00]) > $signed(basis[B22])) begin
         q1_br_in = BR_X;
      end else if ($signed(basis[B11]) > $signed(basis[B22])) begin
         q1_br_in = BR_Y;
      end else begin
         q1_br_in = BR_Z;
      end
   end

   // stage 2: root argument and quotient numerators per branch
   logic signed [ARG_W-1:0]               arg;
   logic signed [NUM_QUAT-1:0][ND_W-1:0]  nd;
   logic [NUM_QUAT-1:0][ND_W-1:0]         nabs;
   logic                                  q2_valid_ff;
   sq_side_type                           q2_side_ff, q2_side_in;
   logic [ARG_W-2:0]                      q2_argc_ff, q2_argc_in;

   always_comb begin
      arg = '0;
      nd  = '0;
      case (q1_br_ff)
         BR_W: begin
            arg   = q1_tr_ff + ONE_Q30;
            nd[0] = nx(q1_b_ff[B21]) - nx(q1_b_ff[B12]);
            nd[1] = nx(q1_b_ff[B02]) - nx(q1_b_ff[B20]);
            nd[2] = nx(q1_b_ff[B10]) - nx(q1_b_ff[B01]);
         end
         BR_X: begin
            arg   = ONE_Q30 + sx(q1_b_ff[B00]) - sx(q1_b_ff[B11]) - sx(q1_b_ff[B22]);
            nd[3] = nx(q1_b_ff[B21]) - nx(q1_b_ff[B12]);
            nd[1] = nx(q1_b_ff[B01]) + nx(q1_b_ff[B10]);
            nd[2] = nx(q1_b_ff[B02]) + nx(q1_b_ff[B20]);
         end
         BR_Y: begin
            arg   = ONE_Q30 + sx(q1_b_ff[B11]) - sx(q1_b_ff[B00]) - sx(q1_b_ff[B22]);
            nd[3] = nx(q1_b_ff[B02]) - nx(q1_b_ff[B20]);
            nd[0] = nx(q1_b_ff[B01]) + nx(q1_b_ff[B10]);
            nd[2] = nx(q1_b_ff[B12]) + nx(q1_b_ff[B21]);
         end
         BR_Z: begin
            arg   = ONE_Q30 + sx(q1_b_ff[B22]) - sx(q1_b_ff[B00]) - sx(q1_b_ff[B11]);
            nd[3] = nx(q1_b_ff[B10]) - nx(q1_b_ff[B01]);
            nd[0] = nx(q1_b_ff[B02]) + nx(q1_b_ff[B20]);
            nd[1] = nx(q1_b_ff[B12]) + nx(q1_b_ff[B21]);
         end
         default: begin
            arg = '0;
            nd  = '0;
         end
      endcase

      // a non-positive argument gives a zero root: clamp and flag
      q2_side_in.deg   = arg[ARG_W-1] || (arg == '0);
      q2_argc_in       = q2_side_in.deg ? '0 : arg[ARG_W-2:0];
      q2_side_in.move  = q1_move_ff;
      q2_side_in.scale = q1_len_ff;
      q2_side_in.br    = q1_br_ff;
      for (int i = 0; i < NUM_QUAT; i++) begin
         q2_side_in.nneg[i] = nd[i][ND_W-1];
         nabs[i]            = q2_side_in.nneg[i] ? (~nd[i] + 1'b1) : nd[i];
         q2_side_in.nmag[i] = nabs[i][DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= in_valid;
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_b_ff    <= basis;
         q1_len_ff  <= len;
         q1_move_ff <= move;
         q1_tr_ff   <= q1_tr_in;
         q1_br_ff   <= q1_br_in;
         q2_side_ff <= q2_side_in;
         q2_argc_ff <= q2_argc_in;
      end
   end

   // r = floor(sqrt(arg * 2^30))
   logic [SQ_OUT_W-1:0] r;

   atd_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand ({1'b0, q2_argc_ff, {FRAC_Q30{1'b0}}}),
      .root     (r)
   );

   logic [SQ_OUT_W-1:0] sq_valid_ff;
   sq_side_type         sq_side_ff [SQ_OUT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '0;
      end else if (en) begin
         sq_valid_ff <= {sq_valid_ff[SQ_OUT_W-2:0], q2_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= q2_side_ff;
         for (int k = 1; k < SQ_OUT_W; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
      end
   end

   // quotients |d| * 2^30 / (2r), one lane per quaternion term
   logic [NUM_QUAT-1:0][DV_Q_W-1:0] quo;
   logic [NUM_QUAT-1:0]             ovf;

   for (genvar i = 0; i < NUM_QUAT; i++) begin : g_div
      atd_div u_div (
         .clock (clock),
         .en    (en),
         .numer ({2'b00, sq_side_ff[SQ_OUT_W-1].nmag[i], {FRAC_Q30{1'b0}}}),
         .denom ({r, 1'b0}),
         .quo   (quo[i]),
         .ovf   (ovf[i])
      );
   end

   logic [DV_Q_W:0] dv_valid_ff;
   dv_side_type     dv_side_ff [DV_Q_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else if (en) begin
         dv_valid_ff <= {dv_valid_ff[DV_Q_W-1:0], sq_valid_ff[SQ_OUT_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_side_ff[0].move  <= sq_side_ff[SQ_OUT_W-1].move;
         dv_side_ff[0].scale <= sq_side_ff[SQ_OUT_W-1].scale;
         dv_side_ff[0].br    <= sq_side_ff[SQ_OUT_W-1].br;
         dv_side_ff[0].nneg  <= sq_side_ff[SQ_OUT_W-1].nneg;
         dv_side_ff[0].deg   <= sq_side_ff[SQ_OUT_W-1].deg;
         dv_side_ff[0].r     <= r;
         for (int k = 1; k <= DV_Q_W; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // final stage: diagonal term r/2, the rest saturated quotients, or zero when the root is zero
   dv_side_type                           tail;
   int unsigned                           diag;
   logic                                  q3_valid_ff;
   logic [NUM_QUAT-1:0][DATA_WIDTH-1:0]   q3_quat_ff, q3_quat_in;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   q3_move_ff;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0]   q3_scale_ff;
   logic                                  q3_deg_ff;

   always_comb begin
      tail = dv_side_ff[DV_Q_W];
      case (tail.br)
         BR_W:    diag = 3;
         BR_X:    diag = 0;
         BR_Y:    diag = 1;
         BR_Z:    diag = 2;
         default: diag = 3;
      endcase
      for (int i = 0; i < NUM_QUAT; i++) begin
         if (i == diag) begin
            q3_quat_in[i] = {1'b0, tail.r[SQ_OUT_W-1:1]};
         end else if (tail.r == '0) begin
            q3_quat_in[i] = '0;
         end else begin
            q3_quat_in[i] = sat(ovf[i], quo[i], tail.nneg[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q3_valid_ff <= 1'b0;
      end else if (en) begin
         q3_valid_ff <= dv_valid_ff[DV_Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q3_quat_ff  <= q3_quat_in;
         q3_move_ff  <= tail.move;
         q3_scale_ff <= tail.scale;
         q3_deg_ff   <= tail.deg;
      end
   end

   assign out_valid = q3_valid_ff;
   assign out_move  = q3_move_ff;
   assign scale     = q3_scale_ff;
   assign quat      = q3_quat_ff;
   assign deg       = q3_deg_ff;

endmodule

@@ rtl/affine_matrix_trs_decompose_top.sv @@
// Affine TRS decomposition, fully pipelined: one beat accepted per cycle unless req_stall is high.
// An accepted request beat passes through two 32-stage root pipelines and two 33-stage divider
// pipelines, then the response register, before it leaves as the response beat.
// Sustained throughput is one beat per cycle while the response side takes beats.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Top level; depends on atd_pkg, atd_basis, atd_quat, atd_sqrt and atd_div.
module affine_matrix_trs_decompose_top import atd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_col0_row0,
   input  logic signed [DATA_WIDTH-1:0] req_col0_row1,
   input  logic signed [DATA_WIDTH-1:0] req_col0_row2,
   input  logic signed [DATA_WIDTH-1:0] req_col1_row0,
   input  logic signed [DATA_WIDTH-1:0] req_col1_row1,
   input  logic signed [DATA_WIDTH-1:0] req_col1_row2,
   input  logic signed [DATA_WIDTH-1:0] req_col2_row0,
   input  logic signed [DATA_WIDTH-1:0] req_col2_row1,
   input  logic signed [DATA_WIDTH-1:0] req_col2_row2,
   input  logic signed [DATA_WIDTH-1:0] req_move_x,
   input  logic signed [DATA_WIDTH-1:0] req_move_y,
   input  logic signed [DATA_WIDTH-1:0] req_move_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_out_move_x,
   output logic signed [DATA_WIDTH-1:0] rsp_out_move_y,
   output logic signed [DATA_WIDTH-1:0] rsp_out_move_z,
   output logic        [DATA_WIDTH-1:0] rsp_scale_x,
   output logic        [DATA_WIDTH-1:0] rsp_scale_y,
   output logic        [DATA_WIDTH-1:0] rsp_scale_z,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   output logic                         rsp_degenerate
);

   logic [NUM_ELEM-1:0][DATA_WIDTH-1:0] elem;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] move;

   // gather the basis, column-major
   assign elem[0] = req_col0_row0;
   assign elem[1] = req_col0_row1;
   assign elem[2] = req_col0_row2;
   assign elem[3] = req_col1_row0;
   assign elem[4] = req_col1_row1;
   assign elem[5] = req_col1_row2;
   assign elem[6] = req_col2_row0;
   assign elem[7] = req_col2_row1;
   assign elem[8] = req_col2_row2;
   assign move[0] = req_move_x;
   assign move[1] = req_move_y;
   assign move[2] = req_move_z;

   // pipeline advance: output register free, being taken, or a bubble at the tail
   logic take;
   logic en;
   logic quat_valid;
   logic rsp_valid_ff;

   assign take      = !rsp_valid_ff || !rsp_stall;
   assign en        = take || !quat_valid;
   assign req_stall = !en;

   logic                                basis_valid;
   logic [NUM_ELEM-1:0][DATA_WIDTH-1:0] basis;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] len;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] basis_move;

   atd_basis u_basis (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .elem      (elem),
      .move      (move),
      .out_valid (basis_valid),
      .basis     (basis),
      .len       (len),
      .out_move  (basis_move)
   );

   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] quat_move;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] quat_scale;
   logic [NUM_QUAT-1:0][DATA_WIDTH-1:0] quat;
   logic                                quat_deg;

   atd_quat u_quat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (basis_valid),
      .basis     (basis),
      .len       (len),
      .move      (basis_move),
      .out_valid (quat_valid),
      .out_move  (quat_move),
      .scale     (quat_scale),
      .quat      (quat),
      .deg       (quat_deg)
   );

   // response register
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] rsp_move_ff;
   logic [NUM_AXIS-1:0][DATA_WIDTH-1:0] rsp_scale_ff;
   logic [NUM_QUAT-1:0][DATA_WIDTH-1:0] rsp_quat_ff;
   logic                                rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= quat_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && quat_valid) begin
         rsp_move_ff  <= quat_move;
         rsp_scale_ff <= quat_scale;
         rsp_quat_ff  <= quat;
         rsp_deg_ff   <= quat_deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_move_x = rsp_move_ff[0];
   assign rsp_out_move_y = rsp_move_ff[1];
   assign rsp_out_move_z = rsp_move_ff[2];
   assign rsp_scale_x    = rsp_scale_ff[0];
   assign rsp_scale_y    = rsp_scale_ff[1];
   assign rsp_scale_z    = rsp_scale_ff[2];
   assign rsp_quat_x     = rsp_quat_ff[0];
   assign rsp_quat_y     = rsp_quat_ff[1];
   assign rsp_quat_z     = rsp_quat_ff[2];
   assign rsp_quat_w     = rsp_quat_ff[3];
   assign rsp_degenerate = rsp_deg_ff;

`ifndef SYNTHESIS
   // input is held back only behind a stalled result with no bubble to absorb it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && quat_valid))
      else $error("request stalled without a blocked response");

   // a finished beat at the tail lands in the response register
   a_tail_lands: assert property (@(posedge clock) disable iff (reset)
      (take && quat_valid) |=> rsp_valid)
      else $error("tail beat lost on its way to the response register");

   // a degenerate beat has a zero root, so every quaternion term is zero
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_quat_x == 0 && rsp_quat_y == 0 && rsp_quat_z == 0 && rsp_quat_w == 0))
      else $error("degenerate beat with a nonzero quaternion");
`endif

endmodule

@@ dv/tb_affine_matrix_trs_decompose_top.sv @@
// Testbench for affine_matrix_trs_decompose_top: directed table, then random matrices.
// Every response beat is checked against a hand-written expectation or a bit-accurate decomposition model.
// Depends on atd_pkg and the block's RTL.
module tb_affine_matrix_trs_decompose_top;
   import atd_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef word_type mat_type[12];   // 9 basis elements (column-major), then move x/y/z

   // response: move x/y/z, scale x/y/z, quat x/y/z/w, then the degenerate flag
   typedef struct {
      word_type w[10];
      logic     deg;
   } trs_type;

   typedef struct {
      mat_type m;
      bit      typed;
      trs_type want;
   } row_type;

   localparam longint Q30      = 64'sd1 << FRAC_Q30;
   localparam int     ITEMS    = 1750;
   localparam int     TAIL     = 200;     // last beats run without idling
   localparam int     LATENCY  = 137;
   localparam int     MAX_CYC  = 400000;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_f[12] = '{default: '0};
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_f[10];
   logic     rsp_degenerate;

   trs_type  pending_q[$];
   int       mismatches = 0;
   int       failures = 0;
   int       cycles = 0;
   int       stall_left = 0;
   bit       quiet = 0;
   bit       done = 0;

   affine_matrix_trs_decompose_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_col0_row0(req_f[0]), .req_col0_row1(req_f[1]), .req_col0_row2(req_f[2]),
      .req_col1_row0(req_f[3]), .req_col1_row1(req_f[4]), .req_col1_row2(req_f[5]),
      .req_col2_row0(req_f[6]), .req_col2_row1(req_f[7]), .req_col2_row2(req_f[8]),
      .req_move_x(req_f[9]), .req_move_y(req_f[10]), .req_move_z(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_move_x(rsp_f[0]), .rsp_out_move_y(rsp_f[1]), .rsp_out_move_z(rsp_f[2]),
      .rsp_scale_x(rsp_f[3]), .rsp_scale_y(rsp_f[4]), .rsp_scale_z(rsp_f[5]),
      .rsp_quat_x(rsp_f[6]), .rsp_quat_y(rsp_f[7]), .rsp_quat_z(rsp_f[8]),
      .rsp_quat_w(rsp_f[9]), .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- decomposition model ----------------
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // root in Q.30 of a Q2.30 argument; negative argument clamps to zero
   function automatic longint root_q30(longint arg, inout bit deg);
      if (arg < 0) begin
         deg = 1;
         arg = 0;
      end
      return longint'(int_sqrt(longint'(unsigned'(arg)) << 30));
   endfunction

   // d / (2r) in Q2.30; zero root yields zero and flags
   function automatic longint ratio_q30(longint d, longint r, inout bit deg);
      if (r == 0) begin
         deg = 1;
         return 0;
      end
      return clamp32((d * Q30) / (2 * r));
   endfunction

   function automatic trs_type decompose(mat_type m);
      longint b[3][3];
      longint q[4];
      longint e[3];
      longint v, tr, r, sl;
      longint unsigned sum, len, a;
      bit deg;
      trs_type t;
      deg = 0;
      for (int c = 0; c < 3; c++) begin
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            v = longint'(m[c*3+k]);
            a = longint'(unsigned'(v < 0 ? -v : v));
            e[k] = v;
            sum += a * a;
         end
         len = int_sqrt(sum);
         t.w[3+c] = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
         sl = longint'(len);
         for (int k = 0; k < 3; k++)
            b[k][c] = (len > 0) ? (e[k] * Q30) / sl : e[k];
      end
      tr = b[0][0] + b[1][1] + b[2][2];
      if (tr > 0) begin
         r = root_q30(tr + Q30, deg);
         q[3] = clamp32(r / 2);
         q[0] = ratio_q30(b[2][1] - b[1][2], r, deg);
         q[1] = ratio_q30(b[0][2] - b[2][0], r, deg);
         q[2] = ratio_q30(b[1][0] - b[0][1], r, deg);
      end else if (b[0][0] > b[1][1] && b[0][0] > b[2][2]) begin
         r = root_q30(Q30 + b[0][0] - b[1][1] - b[2][2], deg);
         q[3] = ratio_q30(b[2][1] - b[1][2], r, deg);
         q[0] = clamp32(r / 2);
         q[1] = ratio_q30(b[0][1] + b[1][0], r, deg);
         q[2] = ratio_q30(b[0][2] + b[2][0], r, deg);
      end else if (b[1][1] > b[2][2]) begin
         r = root_q30(Q30 + b[1][1] - b[0][0] - b[2][2], deg);
         q[3] = ratio_q30(b[0][2] - b[2][0], r, deg);
         q[0] = ratio_q30(b[0][1] + b[1][0], r, deg);
         q[1] = clamp32(r / 2);
         q[2] = ratio_q30(b[1][2] + b[2][1], r, deg);
      end else begin
         r = root_q30(Q30 + b[2][2] - b[0][0] - b[1][1], deg);
         q[3] = ratio_q30(b[1][0] - b[0][1], r, deg);
         q[0] = ratio_q30(b[0][2] + b[2][0], r, deg);
         q[1] = ratio_q30(b[1][2] + b[2][1], r, deg);
         q[2] = clamp32(r / 2);
      end
      for (int k = 0; k < 3; k++) t.w[k] = m[9+k];
      for (int k = 0; k < 4; k++) t.w[6+k] = q[k][31:0];
      t.deg = deg;
      return t;
   endfunction

   // ---------------- request side ----------------
   task automatic send_beat(mat_type m, bit typed, trs_type want);
      trs_type exp_rsp;
      req_valid <= 1'b1;
      for (int k = 0; k < 12; k++) req_f[k] <= m[k];
      do @(posedge clock); while (req_stall);
      if (typed) begin
         exp_rsp = want;
      end else begin
         exp_rsp = decompose(m);
      end
      pending_q = {pending_q, exp_rsp};
      if (!quiet && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic mat_type diag_mat(word_type d0, word_type d1, word_type d2);
      mat_type m = '{default: '0};
      m[0] = d0;
      m[4] = d1;
      m[8] = d2;
      return m;
   endfunction

   function automatic word_type rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return word_type'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
         2: return word_type'($signed($urandom_range(0, 32'h3FF)) - 32'sh200);
         default: return 0;
      endcase
   endfunction

   initial begin
      row_type tbl[$];
      row_type rw;
      mat_type m;
      trs_type none;
      int      mode;
      none = '{w: '{default: '0}, deg: 1'b0};

      // identity: unit scales, unit w
      rw.m = diag_mat(32'sh10000, 32'sh10000, 32'sh10000);
      rw.m[9] = 32'sh7FFF_FFFF; rw.m[10] = 32'sh8000_0000; rw.m[11] = -32'sd1;
      rw.typed = 1;
      rw.want.w = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'h10000, 32'h10000,
                    32'h10000, 0, 0, 0, 32'sh4000_0000};
      rw.want.deg = 0;
      tbl = {tbl, rw};
      // all-zero basis: zero columns stay zero, last branch with z = 0.5
      rw.m = '{default: '0};
      rw.want.w = '{0, 0, 0, 0, 0, 0, 0, 0, 32'sh2000_0000, 0};
      tbl = {tbl, rw};
      // remaining rows go through the model
      rw.typed = 0;
      rw.want = none;
      rw.m = '{default: 32'sh7FFF_FFFF};                      tbl = {tbl, rw};
      rw.m = '{default: 32'sh8000_0000};                      tbl = {tbl, rw};
      rw.m = '{default: -32'sd1};                             tbl = {tbl, rw};
      rw.m = diag_mat(32'sh10000, -32'sh10000, -32'sh10000);  tbl = {tbl, rw};
      rw.m = diag_mat(-32'sh10000, 32'sh10000, -32'sh10000);  tbl = {tbl, rw};
      rw.m = diag_mat(-32'sh10000, -32'sh10000, 32'sh10000);  tbl = {tbl, rw};
      rw.m = diag_mat(-32'sh10000, -32'sh10000, -32'sh10000); tbl = {tbl, rw};
      rw.m = diag_mat(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF); tbl = {tbl, rw};
      // 90 degrees about z, scaled
      rw.m = diag_mat(0, 0, 32'sh20000);
      rw.m[1] = 32'sh30000; rw.m[3] = -32'sh30000;            tbl = {tbl, rw};
      // sheared, non-orthonormal basis
      rw.m = '{default: 32'sh10000};
      rw.m[4] = -32'sh10000;                                  tbl = {tbl, rw};
      rw.m = '{default: 32'sh10000};
      rw.m[0] = 0; rw.m[4] = 0; rw.m[8] = 0;                  tbl = {tbl, rw};
      // single zero column next to a tiny one
      rw.m = diag_mat(0, 1, -1);                              tbl = {tbl, rw};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (tbl[i]) send_beat(tbl[i].m, tbl[i].typed, tbl[i].want);

      // random matrices: mostly moderate Q16.16, some full range, some small, some zero columns
      for (int n = 0; n < ITEMS; n++) begin
         if (n == ITEMS - TAIL) quiet = 1;
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 12; k++) m[k] = rand_word(k >= 9 ? 0 : (mode == 3 ? 1 : mode));
         if ($urandom_range(0, 9) == 0) begin
            mode = $urandom_range(0, 2);
            m[mode*3] = 0; m[mode*3+1] = 0; m[mode*3+2] = 0;
         end
         if ($urandom_range(0, 4) == 0)
            for (int k = 0; k < 3; k++) m[k*4] = m[k*4] + 32'sh10000;
         send_beat(m, 0, none);
      end
      req_valid <= 1'b0;

      // drain, then allow for anything still in flight
      while (pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      done = 1;
   end

   // ---------------- response side ----------------
   always @(posedge clock) begin
      trs_type want;
      bit      bad;
      cycles <= cycles + 1;
      if (done || cycles >= MAX_CYC) begin
         if (cycles >= MAX_CYC) begin
            $display("simulation failed");
         end else if (failures == 0 && pending_q.size() == 0) begin
            $display("simulation ok");
         end else begin
            $display("simulation failed");
         end
         $finish;
      end else begin
         // check an accepted beat against the oldest prediction
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               failures++;
               if (mismatches++ < 10) $display("unexpected response beat at cycle %0d", cycles);
            end else begin
               want = pending_q.pop_front();
               bad = (want.deg !== rsp_degenerate);
               for (int k = 0; k < 10; k++) if (want.w[k] !== rsp_f[k]) bad = 1;
               if (bad) begin
                  failures++;
                  if (mismatches++ < 10) begin
                     $display("mismatch at cycle %0d", cycles);
                     for (int k = 0; k < 10; k++)
                        $display("  word %0d exp %h got %h", k, want.w[k], rsp_f[k]);
                     $display("  degenerate exp %b got %b", want.deg, rsp_degenerate);
                  end
               end
            end
         end
         // random response stall bursts, none once quiet is set
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!quiet && !reset && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule

@@ affine_matrix_trs_decompose_top.f @@
rtl/atd_pkg.sv
rtl/atd_sqrt.sv
rtl/atd_div.sv
rtl/atd_basis.sv
rtl/atd_quat.sv
rtl/affine_matrix_trs_decompose_top.sv
dv/tb_affine_matrix_trs_decompose_top.sv
